[hw/rtl/mst_pkg.sv]
// Shared types, constants and move table for the marching-squares contour tracer.
package mst_pkg;

   localparam int MAX_DIM     = 64;
   localparam int ROW_BITS    = 64;
   localparam int WIDTH_CAP   = (MAX_DIM < ROW_BITS) ? MAX_DIM : ROW_BITS;
   localparam int ROW_IDX_W   = $clog2(MAX_DIM);
   localparam int COL_IDX_W   = $clog2(ROW_BITS);
   localparam int COORD_W     = 7;
   localparam int MOVES_W     = 15;
   localparam int LIMIT_FLOOR = 16;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 7;

   typedef enum logic [1:0] {
      CMD_LOAD   = 2'd0,
      CMD_NEXT   = 2'd1,
      CMD_REWIND = 2'd2
   } command_type;

   typedef enum logic [2:0] {
      ST_POINT    = 3'd0,
      ST_CLOSE    = 3'd1,
      ST_NO_SOLID = 3'd2,
      ST_FAILED   = 3'd3,
      ST_FINISHED = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      MV_NONE  = 3'd0,
      MV_UP    = 3'd1,
      MV_LEFT  = 3'd2,
      MV_DOWN  = 3'd3,
      MV_RIGHT = 3'd4
   } move_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_REGION_WIDTH  = 1'd0,
      CSR_REGION_HEIGHT = 1'd1
   } csr_index_type;

   typedef struct packed {
      logic       mem_write;
      logic       restart;
      logic       scan_start;
      logic       scan_inc;
      logic       scan_sel;
      logic       origin_set;
      logic       step_commit;
      logic       out_load;
      status_type out_status;
   } dp_cmd_type;

   typedef struct packed {
      logic row_hit;
      logic scan_last;
      logic move_none;
      logic limit_hit;
      logic closes;
      logic cfg_hit;
   } dp_status_type;

   // nbr bit 0 top-left, 1 top-right, 2 bottom-left, 3 bottom-right
   function automatic move_type choose_move(logic [3:0] nbr, move_type prev);
      move_type mv;
      case (nbr) inside
         4'd1, 4'd5, 4'd13: mv = MV_UP;
         4'd2, 4'd3, 4'd7:  mv = MV_RIGHT;
         4'd4, 4'd12, 4'd14: mv = MV_LEFT;
         4'd8, 4'd10, 4'd11: mv = MV_DOWN;
         4'd6:              mv = (prev == MV_UP) ? MV_LEFT : MV_RIGHT;
         4'd9:              mv = (prev == MV_RIGHT) ? MV_UP : MV_DOWN;
         default:           mv = MV_NONE;
      endcase
      return mv;
   endfunction

endpackage

[hw/rtl/marching_squares_contour_trace.sv]
// Top level of the marching-squares contour tracer.
//
// Input channel (req_*): valid/ready transactions carrying a command.
//   Load writes req_row_bits into mask row req_row_index; rewind restarts the
//   trace; both give no result. Next gives one result on
//   the rsp_* channel: an outline point, a closing point, or a status.
// A next while tracing reads mask rows y-1 and y from the two read ports of
//   the mask memory, then picks the move and registers the result. The first
//   next after a restart first scans rows, reading and then checking each row,
//   until a row holds a solid pixel in the region or the last row is checked.
// Configuration: csr_we/csr_index/csr_wdata write region width (index 0) and
//   height (index 1); a write restarts the trace. Write only while idle.
// Reset clears the trace to idle and the region to 64 x 64; mask rows hold
//   nothing defined until loaded.
// The result sits in an output register. While it waits for rsp_ready, loads
//   and rewinds are still taken; a next is taken and then holds its result
//   back until the register is free, and req_ready stays low meanwhile.
module marching_squares_contour_trace
   import mst_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_command,
   input  logic [5:0]             req_row_index,
   input  logic [63:0]            req_row_bits,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [6:0]             rsp_point_x,
   output logic [6:0]             rsp_point_y,
   output logic [2:0]             rsp_status,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type st;

   mst_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .st          (st),
      .cmd         (cmd)
   );

   mst_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .st            (st),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_row_index (req_row_index),
      .req_row_bits  (req_row_bits),
      .rsp_point_x   (rsp_point_x),
      .rsp_point_y   (rsp_point_y),
      .rsp_status    (rsp_status)
   );

endmodule

[hw/rtl/mst_ctrl.sv]
// Controller state machine: sequencing of load, scan, step and result handoff.
module mst_ctrl
   import mst_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [1:0]    req_command,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type st,
   output dp_cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_STEP_RD,
      S_STEP
   } state_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_TRACING,
      PH_FINISHED,
      PH_FAILED
   } phase_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      req_take;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign req_take  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      cmd      = '0;
      cmd.out_status = ST_POINT;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               case (req_command)
                  CMD_LOAD: begin
                     cmd.mem_write = 1'b1;
                     cmd.restart   = 1'b1;
                     phase_in      = PH_IDLE;
                  end
                  CMD_REWIND: begin
                     cmd.restart = 1'b1;
                     phase_in    = PH_IDLE;
                  end
                  CMD_NEXT: begin
                     if (phase_ff == PH_IDLE) begin
                        cmd.scan_start = 1'b1;
                        state_in       = S_SCAN_RD;
                     end else begin
                        state_in = S_STEP;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_SCAN_RD: begin
            cmd.scan_sel = 1'b1;
            state_in     = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            cmd.scan_sel = 1'b1;
            if (st.row_hit) begin
               cmd.origin_set = 1'b1;
               phase_in       = PH_TRACING;
               state_in       = S_STEP_RD;
            end else if (st.scan_last) begin
               if (out_free) begin
                  cmd.out_load   = 1'b1;
                  cmd.out_status = ST_NO_SOLID;
                  state_in       = S_IDLE;
               end
            end else begin
               cmd.scan_inc = 1'b1;
               state_in     = S_SCAN_RD;
            end
         end
         S_STEP_RD: begin
            state_in = S_STEP;
         end
         S_STEP: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
               case (phase_ff)
                  PH_FINISHED: cmd.out_status = ST_FINISHED;
                  PH_TRACING: begin
                     if (st.limit_hit || st.move_none) begin
                        cmd.out_status = ST_FAILED;
                        phase_in       = PH_FAILED;
                     end else begin
                        cmd.step_commit = 1'b1;
                        if (st.closes) begin
                           cmd.out_status = ST_CLOSE;
                           phase_in       = PH_FINISHED;
                        end else begin
                           cmd.out_status = ST_POINT;
                        end
                     end
                  end
                  default: cmd.out_status = ST_FAILED;
               endcase
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (st.cfg_hit) begin
         phase_in = PH_IDLE;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_out_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over an untaken result");

   a_next_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_command == CMD_NEXT) |=> (state_ff != S_IDLE))
      else $error("next transaction did not start work");

endmodule

[hw/rtl/mst_datapath.sv]
// Datapath: mask memory, region registers, cursor, move selection and result register.
module mst_datapath
   import mst_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  dp_cmd_type             cmd,
   output dp_status_type          st,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic [5:0]             req_row_index,
   input  logic [63:0]            req_row_bits,
   output logic [6:0]             rsp_point_x,
   output logic [6:0]             rsp_point_y,
   output logic [2:0]             rsp_status
);

   logic [ROW_BITS-1:0] mask_mem [MAX_DIM];
   logic [ROW_BITS-1:0] rd_a_ff, rd_b_ff;
   logic [ROW_IDX_W-1:0] addr_a, addr_b;
   logic                 wr_ok;

   logic [COORD_W-1:0] eff_w_ff, eff_h_ff;
   logic [ROW_BITS-1:0] width_mask_ff;
   logic [MOVES_W-1:0] limit_ff;

   logic [COORD_W-1:0] cursor_x_ff, cursor_y_ff, origin_x_ff, origin_y_ff;
   logic [COORD_W-1:0] scan_y_ff;
   move_type           last_move_ff;
   logic [MOVES_W-1:0] moves_ff;

   logic [COORD_W-1:0] out_x_ff, out_y_ff;
   status_type         out_status_ff;

   logic [COORD_W-1:0] xm1, ym1, new_x, new_y, scan_y_p1;
   logic               col_ok_l, col_ok_r, row_ok_a, row_ok_b;
   logic [3:0]         nbr;
   move_type           mv;
   logic [ROW_BITS-1:0] hit_bits;
   logic [COL_IDX_W-1:0] first_x;
   logic [COORD_W-1:0] wp1, hp1;
   logic [2*COORD_W-1:0] area;
   logic [2*COORD_W+1:0] limit_raw;
   logic               cfg_restart;

   function automatic logic [COORD_W-1:0] saturate(logic [CSR_DATA_W-1:0] v, int cap);
      logic [COORD_W-1:0] r;
      r = COORD_W'(v);
      if (v == '0) begin
         r = COORD_W'(1);
      end else if (32'(v) > 32'(cap)) begin
         r = COORD_W'(cap);
      end
      return r;
   endfunction

   function automatic logic [COL_IDX_W-1:0] lowest_set(logic [ROW_BITS-1:0] bits);
      logic [COL_IDX_W-1:0] idx;
      idx = '0;
      for (int i = ROW_BITS - 1; i >= 0; i--) begin
         if (bits[i]) begin
            idx = COL_IDX_W'(i);
         end
      end
      return idx;
   endfunction

   // memory ports
   assign ym1    = cursor_y_ff - COORD_W'(1);
   assign addr_a = ym1[ROW_IDX_W-1:0];
   assign addr_b = cmd.scan_sel ? scan_y_ff[ROW_IDX_W-1:0] : cursor_y_ff[ROW_IDX_W-1:0];
   assign wr_ok  = cmd.mem_write && (32'(req_row_index) < 32'(MAX_DIM));

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         mask_mem[req_row_index[ROW_IDX_W-1:0]] <= req_row_bits;
      end
      rd_a_ff <= mask_mem[addr_a];
      rd_b_ff <= mask_mem[addr_b];
   end

   // neighborhood around the current corner
   assign xm1      = cursor_x_ff - COORD_W'(1);
   assign col_ok_r = cursor_x_ff < eff_w_ff;
   assign col_ok_l = (cursor_x_ff != '0) && (cursor_x_ff <= eff_w_ff);
   assign row_ok_b = cursor_y_ff < eff_h_ff;
   assign row_ok_a = (cursor_y_ff != '0) && (cursor_y_ff <= eff_h_ff);

   assign nbr[0] = row_ok_a && col_ok_l && rd_a_ff[xm1[COL_IDX_W-1:0]];
   assign nbr[1] = row_ok_a && col_ok_r && rd_a_ff[cursor_x_ff[COL_IDX_W-1:0]];
   assign nbr[2] = row_ok_b && col_ok_l && rd_b_ff[xm1[COL_IDX_W-1:0]];
   assign nbr[3] = row_ok_b && col_ok_r && rd_b_ff[cursor_x_ff[COL_IDX_W-1:0]];

   assign mv = choose_move(nbr, last_move_ff);

   always_comb begin
      new_x = cursor_x_ff;
      new_y = cursor_y_ff;
      case (mv)
         MV_UP:    new_y = ym1;
         MV_LEFT:  new_x = xm1;
         MV_DOWN:  new_y = cursor_y_ff + COORD_W'(1);
         MV_RIGHT: new_x = cursor_x_ff + COORD_W'(1);
         default:  ;
      endcase
   end

   assign hit_bits  = rd_b_ff & width_mask_ff;
   assign first_x   = lowest_set(hit_bits);
   assign scan_y_p1 = scan_y_ff + COORD_W'(1);

   assign cfg_restart = csr_we && (csr_index == CSR_REGION_WIDTH ||
                                   csr_index == CSR_REGION_HEIGHT);

   always_comb begin
      st.row_hit   = |hit_bits;
      st.scan_last = (scan_y_p1 == eff_h_ff);
      st.move_none = (mv == MV_NONE);
      st.limit_hit = (moves_ff >= limit_ff);
      st.closes    = (new_x == origin_x_ff) && (new_y == origin_y_ff);
      st.cfg_hit   = cfg_restart;
   end

   // step limit max(16, 4(W+1)(H+1)), refreshed every cycle from the region registers
   assign wp1       = eff_w_ff + COORD_W'(1);
   assign hp1       = eff_h_ff + COORD_W'(1);
   assign area      = (2*COORD_W)'(wp1) * (2*COORD_W)'(hp1);
   assign limit_raw = {area, 2'b00};

   always_ff @(posedge clock) begin
      if (32'(limit_raw) < 32'(LIMIT_FLOOR)) begin
         limit_ff <= MOVES_W'(LIMIT_FLOOR);
      end else begin
         limit_ff <= limit_raw[MOVES_W-1:0];
      end
      for (int i = 0; i < ROW_BITS; i++) begin
         width_mask_ff[i] <= (32'(i) < 32'(eff_w_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_w_ff <= COORD_W'(WIDTH_CAP);
         eff_h_ff <= COORD_W'(MAX_DIM);
      end else if (csr_we) begin
         case (csr_index)
            CSR_REGION_WIDTH:  eff_w_ff <= saturate(csr_wdata, WIDTH_CAP);
            CSR_REGION_HEIGHT: eff_h_ff <= saturate(csr_wdata, MAX_DIM);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff  <= '0;
         cursor_y_ff  <= '0;
         origin_x_ff  <= '0;
         origin_y_ff  <= '0;
         last_move_ff <= MV_NONE;
         moves_ff     <= '0;
      end else if (cmd.restart || cfg_restart) begin
         last_move_ff <= MV_NONE;
         moves_ff     <= '0;
      end else if (cmd.origin_set) begin
         origin_x_ff  <= COORD_W'(first_x);
         origin_y_ff  <= scan_y_ff;
         cursor_x_ff  <= COORD_W'(first_x);
         cursor_y_ff  <= scan_y_ff;
         last_move_ff <= MV_NONE;
         moves_ff     <= '0;
      end else if (cmd.step_commit) begin
         cursor_x_ff  <= new_x;
         cursor_y_ff  <= new_y;
         last_move_ff <= mv;
         moves_ff     <= moves_ff + MOVES_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         scan_y_ff <= '0;
      end else if (cmd.scan_inc) begin
         scan_y_ff <= scan_y_p1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_status_ff <= cmd.out_status;
         if (cmd.out_status == ST_POINT || cmd.out_status == ST_CLOSE) begin
            out_x_ff <= cursor_x_ff;
            out_y_ff <= cursor_y_ff;
         end else begin
            out_x_ff <= '0;
            out_y_ff <= '0;
         end
      end
   end

   assign rsp_point_x = out_x_ff;
   assign rsp_point_y = out_y_ff;
   assign rsp_status  = out_status_ff;

   a_commit_legal: assert property (@(posedge clock) disable iff (reset)
      cmd.step_commit |-> (!st.move_none && !st.limit_hit))
      else $error("step committed without a legal move");

   a_cursor_in_grid: assert property (@(posedge clock) disable iff (reset)
      (cursor_x_ff <= COORD_W'(WIDTH_CAP)) && (cursor_y_ff <= COORD_W'(MAX_DIM)))
      else $error("cursor left the corner grid");

   a_moves_bounded: assert property (@(posedge clock) disable iff (reset)
      moves_ff <= limit_ff)
      else $error("move count passed the step limit");

endmodule

[tb/sv/contour_check_pkg.sv]
`timescale 1ns / 100ps
// Outline point predictor and result scoreboard for the contour tracer testbench.
package contour_check_pkg;
   import mst_pkg::*;

   typedef enum logic [1:0] {
      TRACE_IDLE = 2'd0,
      TRACE_RUN  = 2'd1,
      TRACE_DONE = 2'd2,
      TRACE_FAIL = 2'd3
   } trace_state_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      status_type         status;
   } outline_point_type;

   class outline_scoreboard;
      logic [ROW_BITS-1:0]   mask [MAX_DIM];
      logic [CSR_DATA_W-1:0] width_reg;
      logic [CSR_DATA_W-1:0] height_reg;
      int                    cur_x, cur_y, org_x, org_y;
      move_type              prev_move;
      int unsigned           moves;
      trace_state_type       state;
      outline_point_type     expected_points [$];
      int unsigned           error_count;

      function new();
         foreach (mask[i]) mask[i] = '0;
         width_reg   = CSR_DATA_W'(MAX_DIM);
         height_reg  = CSR_DATA_W'(MAX_DIM);
         cur_x       = 0;
         cur_y       = 0;
         org_x       = 0;
         org_y       = 0;
         error_count = 0;
         restart();
      endfunction

      function void restart();
         state     = TRACE_IDLE;
         prev_move = MV_NONE;
         moves     = 0;
      endfunction

      function int cols_in_use();
         int w;
         w = width_reg;
         if (w < 1) w = 1;
         if (w > WIDTH_CAP) w = WIDTH_CAP;
         return w;
      endfunction

      function int rows_in_use();
         int h;
         h = height_reg;
         if (h < 1) h = 1;
         if (h > MAX_DIM) h = MAX_DIM;
         return h;
      endfunction

      function bit solid(int x, int y);
         if (x < 0 || y < 0 || x >= cols_in_use() || y >= rows_in_use()) return 1'b0;
         return mask[y][x];
      endfunction

      // neighborhood bits: 0 top-left, 1 top-right, 2 bottom-left, 3 bottom-right
      function move_type pick_move(int x, int y);
         logic [3:0] nbr;
         nbr = {solid(x, y), solid(x - 1, y), solid(x, y - 1), solid(x - 1, y - 1)};
         case (nbr)
            4'd1, 4'd5, 4'd13:  return MV_UP;
            4'd2, 4'd3, 4'd7:   return MV_RIGHT;
            4'd4, 4'd12, 4'd14: return MV_LEFT;
            4'd8, 4'd10, 4'd11: return MV_DOWN;
            4'd6:               return (prev_move == MV_UP) ? MV_LEFT : MV_RIGHT;
            4'd9:               return (prev_move == MV_RIGHT) ? MV_UP : MV_DOWN;
            default:            return MV_NONE;
         endcase
      endfunction

      function outline_point_type trace_next();
         int                w, h, px, py;
         int unsigned       limit;
         bit                found;
         move_type          mv;
         outline_point_type pt;
         w = cols_in_use();
         h = rows_in_use();
         limit = 4 * (w + 1) * (h + 1);
         if (limit < LIMIT_FLOOR) limit = LIMIT_FLOOR;
         pt.x = '0;
         pt.y = '0;
         pt.status = ST_NO_SOLID;
         if (state == TRACE_IDLE) begin
            found = 1'b0;
            for (int y = 0; y < h && !found; y++) begin
               for (int x = 0; x < w && !found; x++) begin
                  if (solid(x, y)) begin
                     org_x = x;
                     org_y = y;
                     found = 1'b1;
                  end
               end
            end
            if (!found) return pt;
            cur_x     = org_x;
            cur_y     = org_y;
            prev_move = MV_NONE;
            moves     = 0;
            state     = TRACE_RUN;
         end
         if (state == TRACE_DONE) begin
            pt.status = ST_FINISHED;
            return pt;
         end
         pt.status = ST_FAILED;
         if (state == TRACE_FAIL) return pt;
         if (moves >= limit) begin
            state = TRACE_FAIL;
            return pt;
         end
         mv = pick_move(cur_x, cur_y);
         if (mv == MV_NONE) begin
            state = TRACE_FAIL;
            return pt;
         end
         px = cur_x;
         py = cur_y;
         case (mv)
            MV_UP:   cur_y--;
            MV_LEFT: cur_x--;
            MV_DOWN: cur_y++;
            default: cur_x++;
         endcase
         prev_move = mv;
         moves++;
         pt.x = px[COORD_W-1:0];
         pt.y = py[COORD_W-1:0];
         if (cur_x == org_x && cur_y == org_y) begin
            state = TRACE_DONE;
            pt.status = ST_CLOSE;
         end else begin
            pt.status = ST_POINT;
         end
         return pt;
      endfunction

      function void write_region(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         if (idx == CSR_REGION_WIDTH) width_reg = val;
         else height_reg = val;
         restart();
      endfunction

      function void note_command(logic [1:0] cmd, logic [ROW_IDX_W-1:0] row,
                                 logic [ROW_BITS-1:0] bits);
         if (cmd == CMD_LOAD) begin
            mask[row] = bits;
            restart();
         end else if (cmd == CMD_NEXT) begin
            expected_points.push_back(trace_next());
         end else if (cmd == CMD_REWIND) begin
            restart();
         end
      endfunction

      task report(string what);
         error_count++;
         if (error_count <= 100) $display("%0t mismatch: %s", $time, what);
      endtask

      task check_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, logic [2:0] status);
         outline_point_type pt;
         if (expected_points.size() == 0) begin
            report($sformatf("result (%0d,%0d) status %0d with none pending", x, y, status));
         end else begin
            pt = expected_points.pop_front();
            if (status !== pt.status)
               report($sformatf("status %0d, predicted %0d", status, pt.status));
            if (x !== pt.x) report($sformatf("point_x %0d, predicted %0d", x, pt.x));
            if (y !== pt.y) report($sformatf("point_y %0d, predicted %0d", y, pt.y));
         end
      endtask

      function int outstanding();
         return expected_points.size();
      endfunction

      function trace_state_type trace_state();
         return state;
      endfunction
   endclass

endpackage

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// Testbench top: drives the contour tracer and checks every outline transaction.
module tb;
   import mst_pkg::*;
   import contour_check_pkg::*;

   localparam int         TARGET_ITEMS  = 1200;
   localparam int         SETTLE_CYCLES = 2 * MAX_DIM + 16;
   localparam int         HOLD_CYCLES   = 300;
   localparam int         CYCLE_LIMIT   = 1000000;
   localparam logic [1:0] CMD_UNKNOWN   = 2'd3;

   localparam int SHAPE_RANDOM = 0;
   localparam int SHAPE_SPARSE = 1;
   localparam int SHAPE_RECT   = 2;
   localparam int SHAPE_EMPTY  = 3;
   localparam int SHAPE_FULL   = 4;
   localparam int SHAPE_CHECK  = 5;

   logic                   clock         = 1'b0;
   logic                   reset         = 1'b1;
   logic                   req_valid     = 1'b0;
   logic                   req_ready;
   logic [1:0]             req_command   = '0;
   logic [5:0]             req_row_index = '0;
   logic [63:0]            req_row_bits  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready     = 1'b0;
   logic [6:0]             rsp_point_x;
   logic [6:0]             rsp_point_y;
   logic [2:0]             rsp_status;
   logic                   csr_we        = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index     = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata     = '0;

   outline_scoreboard board = new();
   int unsigned       cycle_count = 0;
   int unsigned       items_sent  = 0;
   int                calm_left   = 0;
   bit                burst       = 1'b0;
   bit                hold_rsp    = 1'b0;
   bit                hold_active = 1'b0;

   marching_squares_contour_trace u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
      if (!reset) begin
         if (csr_we) board.write_region(csr_index, csr_wdata);
         if (req_valid && req_ready) board.note_command(req_command, req_row_index, req_row_bits);
         if (rsp_valid && rsp_ready) board.check_point(rsp_point_x, rsp_point_y, rsp_status);
      end
   end

   // response side back-pressure
   initial begin
      int k;
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp) begin
            hold_active = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_active = 1'b0;
            hold_rsp = 1'b0;
         end else begin
            k = $urandom_range(0, 99);
            if (k < 45) begin
               rsp_ready <= 1'b1;
               repeat ($urandom_range(1, 40)) @(negedge clock);
            end else if (k < 95) begin
               rsp_ready <= 1'b0;
               repeat ($urandom_range(1, 3)) @(negedge clock);
            end else begin
               rsp_ready <= 1'b0;
               repeat ($urandom_range(10, 60)) @(negedge clock);
            end
         end
      end
   end

   // all driver tasks start and end at a falling edge
   task send_item(logic [1:0] cmd, logic [5:0] row, logic [63:0] bits);
      int k, n;
      n = 0;
      if (!burst) begin
         k = $urandom_range(0, 99);
         if (calm_left > 0) calm_left--;
         else if (k < 4) calm_left = $urandom_range(20, 60);
         else if (k < 62) n = 0;
         else if (k < 93) n = $urandom_range(1, 3);
         else n = $urandom_range(8, 40);
      end
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_command   <= cmd;
      req_row_index <= row;
      req_row_bits  <= bits;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      if (cmd != CMD_UNKNOWN) items_sent++;
   endtask

   task req_stop();
      req_valid <= 1'b0;
      @(negedge clock);
   endtask

   task next_cmd();
      send_item(CMD_NEXT, 6'($urandom), {$urandom, $urandom});
   endtask

   task reconfigure(logic [CSR_DATA_W-1:0] w, logic [CSR_DATA_W-1:0] h);
      req_stop();
      while (board.outstanding() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_REGION_WIDTH;
      csr_wdata <= w;
      @(negedge clock);
      csr_index <= CSR_REGION_HEIGHT;
      csr_wdata <= h;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [CSR_DATA_W-1:0] pick_dim();
      int k;
      k = $urandom_range(0, 99);
      if (k < 55) return CSR_DATA_W'($urandom_range(1, 6));
      if (k < 80) return CSR_DATA_W'($urandom_range(7, 16));
      if (k < 90) return CSR_DATA_W'(MAX_DIM);
      if (k < 95) return CSR_DATA_W'(1);
      if (k < 97) return CSR_DATA_W'(0);
      return CSR_DATA_W'($urandom_range(65, 127));
   endfunction

   function automatic logic [63:0] shape_row(int style, int y, int w,
                                             int x0, int x1, int y0, int y1);
      logic [63:0] noise, span;
      noise = {$urandom, $urandom};
      case (style)
         SHAPE_RANDOM: return noise;
         SHAPE_SPARSE: return noise & {$urandom, $urandom} & {$urandom, $urandom};
         SHAPE_RECT: begin
            span = (~64'd0 >> (64 - (x1 - x0 + 1))) << x0;
            return (y >= y0 && y <= y1) ? span : 64'd0;
         end
         SHAPE_EMPTY: return noise & ~(~64'd0 >> (64 - w));
         SHAPE_FULL:  return ~64'd0;
         default: begin
            span = y[0] ? 64'hAAAA_AAAA_AAAA_AAAA : 64'h5555_5555_5555_5555;
            return span & (noise | {$urandom, $urandom});
         end
      endcase
   endfunction

   task load_shape();
      int w, h, style, x0, x1, y0, y1, r;
      w = board.cols_in_use();
      h = board.rows_in_use();
      style = $urandom_range(SHAPE_RANDOM, SHAPE_CHECK);
      x0 = $urandom_range(0, w - 1);
      x1 = $urandom_range(x0, w - 1);
      y0 = $urandom_range(0, h - 1);
      y1 = $urandom_range(y0, h - 1);
      if (h <= 12) begin
         for (int y = 0; y < h; y++)
            send_item(CMD_LOAD, 6'(y), shape_row(style, y, w, x0, x1, y0, y1));
      end else begin
         repeat ($urandom_range(1, 4)) begin
            r = $urandom_range(0, h - 1);
            send_item(CMD_LOAD, 6'(r), shape_row(style, r, w, x0, x1, y0, y1));
         end
      end
   endtask

   // nexts until the loop closes or fails (plus one past it), no solid pixel, or cap
   task trace_run(int cap);
      int n;
      n = 0;
      while (n < cap) begin
         next_cmd();
         n++;
         if (board.trace_state() == TRACE_IDLE) break;
         if (board.trace_state() == TRACE_DONE || board.trace_state() == TRACE_FAIL) begin
            next_cmd();
            break;
         end
      end
   endtask

   initial begin
      int  k;
      bit  held;
      held = 1'b0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int y = 0; y < MAX_DIM; y++) send_item(CMD_LOAD, 6'(y), 64'd0);

      // directed: empty mask, single pixel at the far corner, rewind, unknown command
      next_cmd();
      send_item(CMD_LOAD, 6'd63, 64'd1 << 63);
      repeat (5) next_cmd();
      send_item(CMD_REWIND, 6'd0, 64'd0);
      next_cmd();
      send_item(CMD_UNKNOWN, 6'd63, ~64'd0);
      // out of range region values saturate
      reconfigure('0, '1);
      send_item(CMD_LOAD, 6'd0, ~64'd0);
      repeat (4) next_cmd();
      // diagonal pairs: both saddle kinds
      reconfigure(CSR_DATA_W'(2), CSR_DATA_W'(2));
      send_item(CMD_LOAD, 6'd0, 64'd1);
      send_item(CMD_LOAD, 6'd1, 64'd2);
      repeat (5) next_cmd();
      send_item(CMD_LOAD, 6'd0, 64'd2);
      send_item(CMD_LOAD, 6'd1, 64'd1);
      repeat (4) next_cmd();

      while (items_sent < TARGET_ITEMS) begin
         k = $urandom_range(0, 99);
         if (!held && items_sent > TARGET_ITEMS / 2) begin
            load_shape();
            req_stop();
            hold_rsp = 1'b1;
            while (!hold_active) @(negedge clock);
            burst = 1'b1;
            repeat (24) next_cmd();
            burst = 1'b0;
            held = 1'b1;
         end else if (k < 8) begin
            reconfigure(pick_dim(), pick_dim());
         end else if (k < 72) begin
            load_shape();
            trace_run(($urandom_range(0, 9) < 7) ? 200 : $urandom_range(1, 20));
            if ($urandom_range(0, 3) == 0) begin
               send_item(CMD_REWIND, 6'($urandom), {$urandom, $urandom});
               trace_run($urandom_range(1, 10));
            end
         end else begin
            repeat ($urandom_range(1, 6))
               send_item(2'($urandom_range(0, 3)), 6'($urandom), {$urandom, $urandom});
         end
      end

      req_stop();
      while (board.outstanding() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (board.error_count == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/mst_pkg.sv
hw/rtl/mst_ctrl.sv
hw/rtl/mst_datapath.sv
hw/rtl/marching_squares_contour_trace.sv
tb/sv/contour_check_pkg.sv
tb/sv/tb.sv
